// ===== design/ssc_pkg.sv =====
`timescale 1ns / 1ps
// ssc_pkg: widths, command codes and angle arithmetic for the servo slew controller
// no dependencies; used by the interfaces, the top level and the checker

package ssc_pkg;

  localparam int KIND_W     = 2;
  localparam int CH_W       = 4;
  localparam int ANGLE_W    = 10;
  localparam int DEG_W      = 8;
  localparam int OFF_W      = 9;
  localparam int INTERVAL_W = 16;

  typedef logic [DEG_W-1:0]      deg_t;
  typedef logic [OFF_W-1:0]      off_t;
  typedef logic [INTERVAL_W-1:0] interval_t;

  // command codes
  localparam logic [KIND_W-1:0] KIND_SET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  localparam deg_t      ANGLE_RESET    = 8'd90;
  localparam deg_t      MAX_DEG        = 8'd180;
  localparam interval_t INTERVAL_RESET = 16'd10;

  localparam off_t OFF_BASE = 9'd204;
  localparam off_t OFF_MAX  = 9'd409;
  // deg*205/180 = deg*41/36, and n/36 == (n*7282) >> 18 for n up to 7380
  localparam int OFF_RECIP = 41 * 7282;
  localparam int OFF_SHIFT = 18;

  function automatic deg_t clamp_angle(input logic signed [ANGLE_W-1:0] ang);
    deg_t res;
    if (ang[ANGLE_W-1]) begin
      res = '0;
    end else if (ang[ANGLE_W-2:0] > 9'(MAX_DEG)) begin
      res = MAX_DEG;
    end else begin
      res = ang[DEG_W-1:0];
    end
    return res;
  endfunction

  function automatic off_t off_of(input deg_t deg);
    logic [26:0] prod;
    prod = 27'(deg) * 27'(OFF_RECIP);
    return OFF_BASE + off_t'(prod[26:OFF_SHIFT]);
  endfunction

endpackage

// ===== design/ssc_cmd_if.sv =====
`timescale 1ns / 1ps
// ssc_cmd_if: command channel (kind, channel, angle) with valid/ready
// depends on ssc_pkg for field widths

interface ssc_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [ssc_pkg::KIND_W-1:0]           kind;
  logic [ssc_pkg::CH_W-1:0]             channel;
  logic signed [ssc_pkg::ANGLE_W-1:0]   angle;

  modport source (output valid, kind, channel, angle, input ready);
  modport sink   (input valid, kind, channel, angle, output ready);
endinterface

// ===== design/ssc_res_if.sv =====
`timescale 1ns / 1ps
// ssc_res_if: result channel (out_channel, off_count, last) with valid/ready
// depends on ssc_pkg for field widths

interface ssc_res_if;
  logic                       valid;
  logic                       ready;
  logic [ssc_pkg::CH_W-1:0]   out_channel;
  logic [ssc_pkg::OFF_W-1:0]  off_count;
  logic                       last;

  modport source (output valid, out_channel, off_count, last, input ready);
  modport sink   (input valid, out_channel, off_count, last, output ready);
endinterface

// ===== design/servo_slew_controller_top.sv =====
`timescale 1ns / 1ps
// servo_slew_controller_top: per-channel servo slewer, angles in two registered-read memories
// depends on ssc_pkg, ssc_cmd_if, ssc_res_if
// target commands and ticks that do not step leave the block idle; an immediate set enters the
// flush state; its result moves from the held register to the output register when that is free
// a stepping tick walks the memories one channel per cycle unless the output stalls; each
// result is held until the next moving channel or the walk ends, to learn if it is last
// reset: angles read as 90 through per-entry valid bits, tick count 0, interval 10

module servo_slew_controller_top #(
  parameter int CHANNELS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ssc_cmd_if.sink                          cmd,
  ssc_res_if.source                        res,
  input  logic                             cfg_we_i,
  input  logic [ssc_pkg::INTERVAL_W-1:0]   cfg_wdata_i
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  state_e                  state_q, state_d;
  ssc_pkg::interval_t      interval_q;
  ssc_pkg::interval_t      tick_q, tick_d;
  logic [IDX_W-1:0]        idx_q, idx_d;        // next entry to read
  logic                    iss_q, iss_d;        // reads still to issue
  logic                    p_valid_q, p_valid_d; // read data is waiting to be processed
  logic [IDX_W-1:0]        p_idx_q, p_idx_d;
  logic                    held_v_q, held_v_d;   // one result held back to learn if it is last
  logic [ssc_pkg::CH_W-1:0] held_ch_q, held_ch_d;
  ssc_pkg::deg_t           held_deg_q, held_deg_d;
  logic                    out_valid_q, out_valid_d;
  logic [ssc_pkg::CH_W-1:0] out_ch_q, out_ch_d;
  ssc_pkg::off_t           out_off_q, out_off_d;
  logic                    out_last_q, out_last_d;

  // ---------------------------------------------------------------------------
  // angle memories: current and target, with valid bits so unwritten entries
  // read as the reset angle
  // ---------------------------------------------------------------------------
  ssc_pkg::deg_t cur_mem [CHANNELS];
  ssc_pkg::deg_t tgt_mem [CHANNELS];
  logic [CHANNELS-1:0] cur_vld_q, tgt_vld_q;

  logic               cur_we, tgt_we;
  logic [IDX_W-1:0]   cur_waddr, tgt_waddr;
  ssc_pkg::deg_t      cur_wdata, tgt_wdata;
  logic               rd_en;
  ssc_pkg::deg_t      cur_rd_q, tgt_rd_q;
  logic               cur_rd_vld_q, tgt_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= tgt_wdata;
    end
    if (rd_en) begin
      cur_rd_q     <= cur_mem[idx_q];
      tgt_rd_q     <= tgt_mem[idx_q];
      cur_rd_vld_q <= cur_vld_q[idx_q];
      tgt_rd_vld_q <= tgt_vld_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= '0;
      tgt_vld_q <= '0;
    end else begin
      if (cur_we) begin
        cur_vld_q[cur_waddr] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld_q[tgt_waddr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------
  ssc_pkg::deg_t   cmd_deg;
  logic [31:0]     cmd_ch_ext;
  logic [IDX_W-1:0] cmd_addr;
  logic            cmd_ch_ok;
  logic [31:0]     p_idx_ext;
  logic [ssc_pkg::CH_W-1:0] p_ch;
  ssc_pkg::deg_t   cur_val, tgt_val, step_val;
  logic            moved;
  logic [ssc_pkg::INTERVAL_W:0] tick_inc, limit;
  logic            out_free, can_proc, advance;
  logic            push, push_last;

  assign cmd_deg    = ssc_pkg::clamp_angle(cmd.angle);
  assign cmd_ch_ext = 32'(cmd.channel);
  assign cmd_addr   = cmd_ch_ext[IDX_W-1:0];
  assign cmd_ch_ok  = cmd_ch_ext < 32'(CHANNELS);

  assign p_idx_ext = 32'(p_idx_q);
  assign p_ch      = p_idx_ext[ssc_pkg::CH_W-1:0];

  assign cur_val  = cur_rd_vld_q ? cur_rd_q : ssc_pkg::ANGLE_RESET;
  assign tgt_val  = tgt_rd_vld_q ? tgt_rd_q : ssc_pkg::ANGLE_RESET;
  assign moved    = cur_val != tgt_val;
  assign step_val = (tgt_val > cur_val) ? cur_val + 8'd1 : cur_val - 8'd1;

  // a zero interval behaves as one
  assign tick_inc = 17'(tick_q) + 17'd1;
  assign limit    = (interval_q == '0) ? 17'd1 : 17'(interval_q);

  // the output register can take a new transfer this cycle
  assign out_free = !out_valid_q || res.ready;
  // a moving channel pushes the held result out, which needs a free output
  assign can_proc = !(moved && held_v_q) || out_free;
  assign advance  = !p_valid_q || can_proc;

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    idx_d       = idx_q;
    iss_d       = iss_q;
    p_valid_d   = p_valid_q;
    p_idx_d     = p_idx_q;
    held_v_d    = held_v_q;
    held_ch_d   = held_ch_q;
    held_deg_d  = held_deg_q;
    cur_we      = 1'b0;
    tgt_we      = 1'b0;
    cur_waddr   = cmd_addr;
    tgt_waddr   = cmd_addr;
    cur_wdata   = cmd_deg;
    tgt_wdata   = cmd_deg;
    rd_en       = 1'b0;
    push        = 1'b0;
    push_last   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.kind)
            ssc_pkg::KIND_SET: begin
              if (cmd_ch_ok) begin
                cur_we     = 1'b1;
                tgt_we     = 1'b1;
                held_v_d   = 1'b1;
                held_ch_d  = cmd.channel;
                held_deg_d = cmd_deg;
                state_d    = ST_FLUSH;
              end
            end
            ssc_pkg::KIND_TARGET: begin
              tgt_we = cmd_ch_ok;
            end
            ssc_pkg::KIND_TICK: begin
              if (tick_inc < limit) begin
                tick_d = tick_inc[ssc_pkg::INTERVAL_W-1:0];
              end else begin
                tick_d  = '0;
                idx_d   = '0;
                iss_d   = 1'b1;
                state_d = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        // process the entry whose read data is waiting
        if (p_valid_q && can_proc && moved) begin
          cur_we     = 1'b1;
          cur_waddr  = p_idx_q;
          cur_wdata  = step_val;
          push       = held_v_q;
          held_v_d   = 1'b1;
          held_ch_d  = p_ch;
          held_deg_d = step_val;
        end
        // issue the next read when the pipeline moves
        if (advance) begin
          p_valid_d = 1'b0;
          if (iss_q) begin
            rd_en     = 1'b1;
            p_valid_d = 1'b1;
            p_idx_d   = idx_q;
            if (idx_q == LAST_IDX) begin
              iss_d = 1'b0;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
        end
        if (!iss_q && !p_valid_q) begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (!held_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          held_v_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // output register
    out_valid_d = out_valid_q;
    out_ch_d    = out_ch_q;
    out_off_d   = out_off_q;
    out_last_d  = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_ch_d    = held_ch_q;
      out_off_d   = ssc_pkg::off_of(held_deg_q);
      out_last_d  = push_last;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      interval_q  <= ssc_pkg::INTERVAL_RESET;
      tick_q      <= '0;
      idx_q       <= '0;
      iss_q       <= 1'b0;
      p_valid_q   <= 1'b0;
      p_idx_q     <= '0;
      held_v_q    <= 1'b0;
      held_ch_q   <= '0;
      held_deg_q  <= '0;
      out_valid_q <= 1'b0;
      out_ch_q    <= '0;
      out_off_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      tick_q      <= tick_d;
      idx_q       <= idx_d;
      iss_q       <= iss_d;
      p_valid_q   <= p_valid_d;
      p_idx_q     <= p_idx_d;
      held_v_q    <= held_v_d;
      held_ch_q   <= held_ch_d;
      held_deg_q  <= held_deg_d;
      out_valid_q <= out_valid_d;
      out_ch_q    <= out_ch_d;
      out_off_q   <= out_off_d;
      out_last_q  <= out_last_d;
    end
  end

  // commands are taken only between walks
  assign cmd.ready       = state_q == ST_IDLE;
  assign res.valid       = out_valid_q;
  assign res.out_channel = out_ch_q;
  assign res.off_count   = out_off_q;
  assign res.last        = out_last_q;

endmodule

// ===== design/ssc_checker.sv =====
`timescale 1ns / 1ps
// ssc_checker: port-level assertions for the servo slew controller, bound to the top level
// depends on ssc_pkg and servo_slew_controller_top

module ssc_checker #(
  parameter int CHANNELS = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cmd_valid,
  input logic                              cmd_ready,
  input logic [ssc_pkg::KIND_W-1:0]        cmd_kind,
  input logic [ssc_pkg::CH_W-1:0]          cmd_channel,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [ssc_pkg::CH_W-1:0]          res_channel,
  input logic [ssc_pkg::OFF_W-1:0]         res_off,
  input logic                              res_last
);

  logic set_ok;
  assign set_ok = cmd_valid && cmd_ready && (cmd_kind == ssc_pkg::KIND_SET)
                  && (32'(cmd_channel) < 32'(CHANNELS));

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_channel) && $stable(res_off)
                                && $stable(res_last))
    else $error("result changed while stalled");

  a_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_off >= ssc_pkg::OFF_BASE) && (res_off <= ssc_pkg::OFF_MAX))
    else $error("off count outside pulse range");

  // an immediate set makes the command side busy; the block holds it busy until its result enters the output register
  a_set_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_ok |=> !cmd_ready)
    else $error("command taken during immediate set");

  // a target command does not stall the block: the command side stays ready
  a_target_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_ready && (cmd_kind == ssc_pkg::KIND_TARGET) |=> cmd_ready)
    else $error("target command stalled the block");

endmodule

bind servo_slew_controller_top ssc_checker #(.CHANNELS(CHANNELS)) u_ssc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_kind    (cmd.kind),
  .cmd_channel (cmd.channel),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_channel (res.out_channel),
  .res_off     (res.off_count),
  .res_last    (res.last)
);
